@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skipped while reset is asserted.
`define VAPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define VAPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/vapd_pkg.sv @@
// Package: shared types, codes and helpers of the sound-chunk decoder.
package vapd_pkg;

    localparam int unsigned MODE_W = 3;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // codec_mode register values
    localparam logic [MODE_W-1:0] MODE_U8     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADPCM4 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADPCM3 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADPCM2 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_S16    = 3'd4;

    localparam logic signed [SAMPLE_W:0] CLAMP_HI = 17'sd16384;
    localparam logic signed [SAMPLE_W:0] CLAMP_LO = -17'sd16384;
    localparam logic [1:0] STEP_MAX = 2'd3;

    // work classes passed from the front end to the back end
    typedef enum logic [2:0] {
        OP_EMIT   = 3'd0,  // value is the finished sample
        OP_SEED   = 3'd1,  // value seeds the predictor and is emitted
        OP_ADPCM4 = 3'd2,  // two 4-bit codes in value[7:0]
        OP_ADPCM3 = 3'd3,  // 3-bit, 3-bit, 2-bit codes in value[7:0]
        OP_ADPCM2 = 3'd4   // four 2-bit codes in value[7:0]
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] value;
    } cmd_t;

    // unsigned 8-bit PCM to signed 16-bit: (b - 128) * 128
    function automatic logic [SAMPLE_W-1:0] pcm8_to_s16(input logic [7:0] b);
        pcm8_to_s16 = {~b[7], ~b[7], b[6:0], 7'b0};
    endfunction

endpackage

@@ design/vapd_front.sv @@
// Front end: accept bytes, track chunk and pairing state, classify into commands.
module vapd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vapd_pkg::MODE_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          in_start,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output vapd_pkg::cmd_t                cmd
);
    import vapd_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              phase_reg, phase_next;
    logic [7:0]        held_reg, held_next;
    logic              seen_reg, seen_next;
    logic              accept;
    logic              phase_eff;
    logic              has_cmd;

    assign in_ready  = cmd_ready;
    assign accept    = in_valid && cmd_ready;
    assign cmd_valid = accept && has_cmd;
    assign phase_eff = in_start ? 1'b0 : phase_reg;

    always_comb
    begin
        mode_next  = cfg_we ? cfg_wdata : mode_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        seen_next  = seen_reg;
        has_cmd    = 1'b0;
        cmd.op     = OP_EMIT;
        cmd.value  = pcm8_to_s16(in_byte);
        if (accept)
        begin
            unique case (mode_reg) inside
                MODE_U8:
                begin
                    phase_next = phase_eff;
                    has_cmd    = 1'b1;
                end
                MODE_S16:
                begin
                    if (!phase_eff)
                    begin
                        held_next  = in_byte;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        has_cmd    = 1'b1;
                        cmd.value  = {in_byte, held_reg};
                    end
                end
                MODE_ADPCM4, MODE_ADPCM3, MODE_ADPCM2:
                begin
                    phase_next = phase_eff;
                    has_cmd    = 1'b1;
                    if (in_start || !seen_reg)
                    begin
                        seen_next = 1'b1;
                        cmd.op    = OP_SEED;
                    end
                    else
                    begin
                        cmd.value = {8'b0, in_byte};
                        if (mode_reg == MODE_ADPCM4)
                            cmd.op = OP_ADPCM4;
                        else if (mode_reg == MODE_ADPCM3)
                            cmd.op = OP_ADPCM3;
                        else
                            cmd.op = OP_ADPCM2;
                    end
                end
                default:
                begin
                    // undefined mode: drop the byte, keep all state
                    has_cmd = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_U8;
            phase_reg <= 1'b0;
            held_reg  <= 8'd0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

@@ design/vapd_queue.sv @@
// Short command queue between front end and back end.
module vapd_queue
#(
    parameter int unsigned DEPTH = vapd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  vapd_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output vapd_pkg::cmd_t pop_cmd
);
    import vapd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ design/vapd_back.sv @@
// Back end: run commands, one ADPCM code per cycle unless stalled, into the output register.
module vapd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  vapd_pkg::cmd_t                cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vapd_pkg::SAMPLE_W-1:0] out_sample,
    output logic                          out_last
);
    import vapd_pkg::*;

    logic [SAMPLE_W-1:0]        pred_reg, pred_next;
    logic [1:0]                 step_reg, step_next;
    logic [1:0]                 idx_reg, idx_next;
    logic                       ovalid_reg, ovalid_next;
    logic [SAMPLE_W-1:0]        osample_reg, osample_next;
    logic                       olast_reg, olast_next;

    logic                       advance;
    logic                       is_last;
    logic [1:0]                 last_idx;
    logic [2:0]                 mag;
    logic                       neg;
    logic [2:0]                 thresh;
    logic [1:0]                 xshift;
    logic [3:0]                 nib;
    logic [2:0]                 amt;
    logic [7:0]                 shifted;
    logic signed [SAMPLE_W:0]   dmag;
    logic signed [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0]        clamped;

    assign advance    = cmd_valid && (!ovalid_reg || out_ready);
    assign is_last    = (idx_reg == last_idx);
    assign cmd_ready  = advance && is_last;
    assign out_valid  = ovalid_reg;
    assign out_sample = osample_reg;
    assign out_last   = olast_reg;

    // pick the code for this cycle: sign bit, magnitude, step-up threshold, extra shift
    always_comb
    begin
        last_idx = 2'd0;
        mag      = 3'd0;
        neg      = 1'b0;
        thresh   = 3'd1;
        xshift   = 2'd0;
        nib      = 4'd0;
        unique case (cmd.op)
            OP_ADPCM4:
            begin
                last_idx = 2'd1;
                thresh   = 3'd5;
                nib      = idx_reg[0] ? cmd.value[3:0] : cmd.value[7:4];
                neg      = nib[3];
                mag      = nib[2:0];
            end
            OP_ADPCM3:
            begin
                last_idx = 2'd2;
                case (idx_reg)
                    2'd0:    nib = {1'b0, cmd.value[7:5]};
                    2'd1:    nib = {1'b0, cmd.value[4:2]};
                    default: nib = {2'b0, cmd.value[1:0]};
                endcase
                if (idx_reg == 2'd2)
                begin
                    neg = nib[1];
                    mag = {2'b0, nib[0]};
                end
                else
                begin
                    thresh = 3'd3;
                    neg    = nib[2];
                    mag    = {1'b0, nib[1:0]};
                end
            end
            OP_ADPCM2:
            begin
                last_idx = 2'd3;
                xshift   = 2'd2;
                case (idx_reg)
                    2'd0:    nib = {2'b0, cmd.value[7:6]};
                    2'd1:    nib = {2'b0, cmd.value[5:4]};
                    2'd2:    nib = {2'b0, cmd.value[3:2]};
                    default: nib = {2'b0, cmd.value[1:0]};
                endcase
                neg = nib[1];
                mag = {2'b0, nib[0]};
            end
            default:
            begin
                last_idx = 2'd0;
            end
        endcase
    end

    // difference = magnitude << (step + 7 + shift), add and clamp
    always_comb
    begin
        amt     = {1'b0, step_reg} + {1'b0, xshift};
        shifted = 8'({5'b0, mag} << amt);
        dmag    = $signed({2'b0, shifted, 7'b0});
        sum     = $signed({pred_reg[SAMPLE_W-1], pred_reg}) + (neg ? -dmag : dmag);
        if (sum > CLAMP_HI)
            clamped = CLAMP_HI[SAMPLE_W-1:0];
        else if (sum < CLAMP_LO)
            clamped = CLAMP_LO[SAMPLE_W-1:0];
        else
            clamped = sum[SAMPLE_W-1:0];
    end

    always_comb
    begin
        pred_next    = pred_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        osample_next = osample_reg;
        olast_next   = olast_reg;
        if (advance)
        begin
            ovalid_next = 1'b1;
            olast_next  = is_last;
            idx_next    = is_last ? 2'd0 : idx_reg + 2'd1;
            case (cmd.op)
                OP_EMIT:
                begin
                    osample_next = cmd.value;
                end
                OP_SEED:
                begin
                    osample_next = cmd.value;
                    pred_next    = cmd.value;
                    step_next    = 2'd0;
                end
                default:
                begin
                    osample_next = clamped;
                    pred_next    = clamped;
                    if (mag >= thresh && step_reg < STEP_MAX)
                        step_next = step_reg + 2'd1;
                    else if (mag == 3'd0 && step_reg != 2'd0)
                        step_next = step_reg - 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg   <= '0;
            step_reg   <= 2'd0;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pred_reg   <= pred_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osample_reg <= osample_next;
        olast_reg   <= olast_next;
    end

endmodule

@@ design/voice_adpcm_pcm_decoder.sv @@
// Top level of the sound-chunk decoder: front end, command queue, back end.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata = data_byte, tuser = chunk_start
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata = sample, tlast = last
//  cfg       in   cfg_we (no back-pressure)      cfg_wdata = codec_mode
//
// Output: the back end emits one sample per cycle while the output is not stalled;
// a byte yields one sample in the PCM modes and for a seed, and 2, 3 or 4 samples
// for a 4-bit, 2.6-bit or 2-bit ADPCM byte; a held s16 low byte yields none.
// Sustained rate is set by the back end's single code-decode unit.
// Reset (rst_n low, asynchronous) empties the queue and output register, clears
// predictor, step, pairing and seed state, and selects unsigned 8-bit PCM.
// A stalled output holds its word and backs up into the queue; the input side
// keeps taking words until the queue is full.
module voice_adpcm_pcm_decoder
#(
    parameter int unsigned QUEUE_DEPTH = vapd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // codec_mode
    input  logic                          cfg_we,
    input  logic [vapd_pkg::MODE_W-1:0]   cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                    s_axis_tuser,   // [0] chunk_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [vapd_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [15:0] sample
    output logic                          m_axis_tlast
);
    import vapd_pkg::*;

    // front end to queue
    logic cmd_in_valid;
    logic cmd_in_ready;
    cmd_t cmd_in;
    // queue to back end
    logic cmd_out_valid;
    logic cmd_out_ready;
    cmd_t cmd_out;

    // classify each byte; hold mode, pairing and seed state
    vapd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_start  (s_axis_tuser[0]),
        .cmd_valid (cmd_in_valid),
        .cmd_ready (cmd_in_ready),
        .cmd       (cmd_in)
    );

    // decouple the two sides so each may stall on its own
    vapd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_in_valid),
        .push_ready (cmd_in_ready),
        .push_cmd   (cmd_in),
        .pop_valid  (cmd_out_valid),
        .pop_ready  (cmd_out_ready),
        .pop_cmd    (cmd_out)
    );

    // decode codes against the predictor and drive the output register
    vapd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_out_valid),
        .cmd_ready  (cmd_out_ready),
        .cmd        (cmd_out),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

@@ design/vapd_checker.sv @@
// Port-level checker of the sound-chunk decoder and its bind to the top level.
`include "assert_macros.svh"

module vapd_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [vapd_pkg::SAMPLE_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import vapd_pkg::*;

    // words taken since the last word with tlast
    logic [2:0] run_reg, run_next;
    logic       out_take;

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        run_next = run_reg;
        if (out_take)
            run_next = m_axis_tlast ? 3'd0 : ((run_reg == 3'd7) ? run_reg : run_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 3'd0;
        else
            run_reg <= run_next;
    end

    `VAPD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")
    `VAPD_ASSERT_ALWAYS(a_rst_no_out, !rst_n |-> !m_axis_tvalid, "output valid during reset")
    `VAPD_ASSERT_ALWAYS(a_ready_after_rst, $past(!rst_n) && rst_n |-> s_axis_tready, "input not ready after reset")
    `VAPD_ASSERT(a_last_run, run_reg <= 3'd3, "more than four words for one byte")

endmodule

bind voice_adpcm_pcm_decoder vapd_checker u_vapd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the sound-chunk decoder: directed and random chunks, all codecs.
`timescale 1ns / 100ps

module tb_top;

    import vapd_pkg::*;

    // Codec values outside the defined set; the block must ignore words while one is selected.
    localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

    localparam int CLAMP_LEVEL   = 16384;
    localparam int ADPCM2_SHIFT  = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 16;      // enough for a word to cross queue and back end
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off for the pressure test
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 70;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } pcm_word_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we = 1'b0;
    logic [MODE_W-1:0]   cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;     // [7:0] data_byte
    logic [0:0]          s_axis_tuser = '0;     // [0] chunk_start
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;          // [15:0] sample
    logic                m_axis_tlast;          // last sample of the current input word

    // Decoder state as the testbench tracks it
    logic [MODE_W-1:0]   mode_q = MODE_U8;
    logic signed [15:0]  pred_q = '0;
    logic [1:0]          step_q = '0;
    logic [7:0]          low_byte_q = '0;
    logic                pair_phase_q = 1'b0;
    logic                seeded_q = 1'b0;

    pcm_word_t           pending_samples[$];

    int                  errors = 0;
    int                  words_sent = 0;
    int                  samples_checked = 0;
    int                  cycle_count = 0;
    int                  rx_gap_left = 0;
    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;
    bit                  rx_hold = 1'b0;
    event                hold_off_ev;

    voice_adpcm_pcm_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sample prediction
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Unsigned 8-bit PCM level, centred on 128 and scaled up by 128.
    function automatic logic [15:0] pcm8_level(input logic [7:0] b);
        int v;
        v = (int'(b) - 128) * 128;
        return v[15:0];
    endfunction

    function automatic void queue_sample(input logic [15:0] s, input logic is_last);
        pcm_word_t w;
        w.sample = s;
        w.last   = is_last;
        pending_samples.push_back(w);
    endfunction

    // Apply one sign-magnitude code to the predictor; clamp, then adapt the step.
    function automatic logic [15:0] adpcm_code(input logic [3:0] code, input int nbits,
                                               input int shift);
        int mag;
        int diff;
        int nxt;
        mag  = int'(code) & ((1 << (nbits - 1)) - 1);
        diff = mag << (int'(step_q) + 7 + shift);
        if (code[nbits - 1])
            diff = -diff;
        nxt = int'(pred_q) + diff;
        if (nxt > CLAMP_LEVEL)
            nxt = CLAMP_LEVEL;
        if (nxt < -CLAMP_LEVEL)
            nxt = -CLAMP_LEVEL;
        pred_q = nxt[15:0];
        if (mag >= 2 * nbits - 3 && step_q < STEP_MAX)
            step_q = step_q + 2'd1;
        else if (mag == 0 && step_q > 2'd0)
            step_q = step_q - 2'd1;
        return nxt[15:0];
    endfunction

    // Work out the samples one accepted word yields and queue them in order.
    function automatic void decode_byte(input logic [7:0] b, input logic start);
        if (mode_q > MODE_S16)
            return;
        if (start)
            pair_phase_q = 1'b0;
        if (mode_q == MODE_U8)
        begin
            queue_sample(pcm8_level(b), 1'b1);
        end
        else if (mode_q == MODE_S16)
        begin
            if (!pair_phase_q)
            begin
                low_byte_q   = b;
                pair_phase_q = 1'b1;
            end
            else
            begin
                pair_phase_q = 1'b0;
                queue_sample({b, low_byte_q}, 1'b1);
            end
        end
        else if (start || !seeded_q)
        begin
            pred_q   = pcm8_level(b);
            step_q   = '0;
            seeded_q = 1'b1;
            queue_sample(pred_q, 1'b1);
        end
        else if (mode_q == MODE_ADPCM4)
        begin
            queue_sample(adpcm_code(b[7:4], 4, 0), 1'b0);
            queue_sample(adpcm_code(b[3:0], 4, 0), 1'b1);
        end
        else if (mode_q == MODE_ADPCM3)
        begin
            queue_sample(adpcm_code(b[7:5], 3, 0), 1'b0);
            queue_sample(adpcm_code(b[4:2], 3, 0), 1'b0);
            queue_sample(adpcm_code(b[1:0], 2, 0), 1'b1);
        end
        else
        begin
            queue_sample(adpcm_code(b[7:6], 2, ADPCM2_SHIFT), 1'b0);
            queue_sample(adpcm_code(b[5:4], 2, ADPCM2_SHIFT), 1'b0);
            queue_sample(adpcm_code(b[3:2], 2, ADPCM2_SHIFT), 1'b0);
            queue_sample(adpcm_code(b[1:0], 2, ADPCM2_SHIFT), 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word from a falling edge; hold it until taken, then predict its samples.
    // tvalid stays high between back-to-back words, so it is never dropped and raised
    // again in the same step.
    task automatic send_word(input logic [7:0] b, input logic start);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(b, start);
        words_sent++;
        @(negedge clk);
    endtask

    // Drop tvalid, wait for every expected sample, then let the back end settle, since a
    // held low byte or an ignored word leaves nothing to wait for.
    task automatic wait_drain();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        if (pending_samples.size() != 0)
        begin
            $error("%0d expected samples never arrived", pending_samples.size());
            errors++;
            pending_samples.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write codec_mode only once the block has gone idle.
    task automatic set_mode(input logic [MODE_W-1:0] m);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        mode_q     = m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Drive tready: random gaps when enabled, and a forced hold while rx_hold is set.
    always @(negedge clk)
    begin
        if (rx_gap_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0)
            rx_gap_left = pick_gap();
        if (rx_hold || rx_gap_left != 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
        if (rx_gap_left != 0)
            rx_gap_left--;
    end

    // Long hold-off, counted here so the sender keeps offering words meanwhile.
    always
    begin : hold_off
        @(hold_off_ev);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Compare every word taken from the output with the oldest expected sample.
    always @(posedge clk)
    begin : check_samples
        pcm_word_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample %0d (last %0b) with nothing expected",
                       $signed(m_axis_tdata), m_axis_tlast);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (m_axis_tdata !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d",
                           $signed(want.sample), $signed(m_axis_tdata));
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    errors++;
                end
                samples_checked++;
            end
        end
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset no seed has been taken, so the first ADPCM word seeds
    // the predictor even without chunk_start.
    task automatic test_unseeded_start();
        set_mode(MODE_ADPCM2);
        send_word(8'h00, 1'b0);
        send_word(8'h55, 1'b0);
    endtask

    task automatic test_pcm8();
        set_mode(MODE_U8);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
    endtask

    // Full-scale pairs, then a chunk start in mid-pair that restarts the pairing.
    task automatic test_pcm16();
        set_mode(MODE_S16);
        send_word(8'h00, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h7F, 1'b0);
    endtask

    // Push the predictor into the upper clamp and walk the step up and down again.
    task automatic test_adpcm_extremes();
        set_mode(MODE_ADPCM4);
        send_word(8'hFF, 1'b1);
        send_word(8'h77, 1'b0);
        send_word(8'h88, 1'b0);
        send_word(8'hFF, 1'b0);
        set_mode(MODE_ADPCM3);
        send_word(8'h80, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
    endtask

    // Keep decoder state across codec changes inside a chunk.
    task automatic test_mode_switch();
        set_mode(MODE_ADPCM2);
        send_word(8'hD2, 1'b0);
        // a held low byte survives a spell of u8 PCM without chunk_start ...
        set_mode(MODE_S16);
        send_word(8'h34, 1'b0);
        set_mode(MODE_U8);
        send_word(8'h7E, 1'b0);
        set_mode(MODE_S16);
        send_word(8'hA5, 1'b0);
        // ... but a chunk start in u8 PCM resets the pairing
        send_word(8'h11, 1'b0);
        set_mode(MODE_U8);
        send_word(8'h22, 1'b1);
        set_mode(MODE_S16);
        send_word(8'h33, 1'b0);
        send_word(8'h44, 1'b0);
    endtask

    // Undefined codecs swallow words and leave the ADPCM state untouched.
    task automatic test_undefined_mode();
        set_mode(MODE_RSVD_LO);
        send_word(8'h5A, 1'b0);
        send_word(8'hC3, 1'b1);
        set_mode(MODE_RSVD_HI);
        send_word(8'hFF, 1'b0);
        set_mode(MODE_ADPCM2);
        send_word(8'h3C, 1'b0);
    endtask

    // Stall the output for a long stretch while words keep coming, so the queue
    // fills and the input side backs off.
    task automatic test_backpressure();
        set_mode(MODE_ADPCM2);
        tx_idle_en = 1'b0;
        -> hold_off_ev;
        send_word(8'h80, 1'b1);
        repeat (20)
            send_word(8'($urandom_range(0, 255)), 1'b0);
        tx_idle_en = 1'b1;
    endtask

    // Random chunks under random codecs: mostly well-formed, with a stray chunk
    // start now and then and the odd chunk that begins without one.
    task automatic test_random_chunks(input int target);
        int sent;
        int len;
        logic start;
        sent = 0;
        while (sent < target)
        begin
            set_mode(MODE_W'($urandom_range(int'(MODE_U8), int'(MODE_S16))));
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3))
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    if (i == 0)
                        start = ($urandom_range(0, 9) != 0);
                    else
                        start = ($urandom_range(0, 11) == 0);
                    send_word(8'($urandom_range(0, 255)), start);
                    sent++;
                end
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        // assert reset from time zero with a real falling edge, then release it
        // away from the rising edge
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_unseeded_start();
        test_pcm8();
        test_pcm16();
        test_adpcm_extremes();
        test_mode_switch();
        test_undefined_mode();
        test_backpressure();
        test_random_chunks(RANDOM_WORDS);
        wait_drain();

        $display("tb: %0d words sent, %0d samples checked", words_sent, samples_checked);
        $display("tb: covered u8/s16 PCM, three ADPCM codecs, undefined codecs and a long stall");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/vapd_pkg.sv
design/vapd_front.sv
design/vapd_queue.sv
design/vapd_back.sv
design/voice_adpcm_pcm_decoder.sv
design/vapd_checker.sv
verif/tb_top.sv
